[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/sac_pkg.sv]
// ----------------------------------------------------------------------------
// Segment allocator package
// Types and constants shared by the segment allocator modules.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LENGTH = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } seg_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_HOLE   = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_ZERO      = 3'd3,
    STAT_NO_OBJECT = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_HSCAN,
    ST_A_HUPD,
    ST_A_HREM,
    ST_A_OSCAN,
    ST_A_OSHIFT,
    ST_F_OSCAN,
    ST_F_HSCAN,
    ST_F_JOIN,
    ST_F_HREM,
    ST_F_HSHIFT,
    ST_F_OREM,
    ST_DONE
  } state_t;

endpackage

[src/sac_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sac_scan.sv]
// ----------------------------------------------------------------------------
// Table scan unit
// Walks a sorted table one entry per cycle and finds the first entry whose
// start equals, or is not below, a key.
// ----------------------------------------------------------------------------
module sac_scan #(
  parameter int CW = 7,
  parameter int AW = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic                      ge_mode,
  input  logic [sac_pkg::ADDR_W-1:0] key,
  input  logic [CW-1:0]             count,
  input  sac_pkg::seg_t             rdata,
  output logic [AW-1:0]             rd_addr,
  output logic                      done,
  output logic                      hit,
  output logic [CW-1:0]             idx,
  output sac_pkg::seg_t             cur,
  output sac_pkg::seg_t             prev
);
  import sac_pkg::*;

  logic              active;
  logic              pend;
  logic [CW-1:0]     c;
  logic [CW-1:0]     cnt;
  logic [ADDR_W-1:0] key_q;
  logic              ge_q;
  logic              match;

  assign rd_addr = c[AW-1:0];
  assign match   = ge_q ? !(rdata.start < key_q) : (rdata.start == key_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        pend   <= 1'b0;
        c      <= '0;
        cnt    <= count;
        key_q  <= key;
        ge_q   <= ge_mode;
      end else if (active) begin
        c    <= c + 1'b1;
        pend <= 1'b1;
        if (!pend) begin
          if (cnt == '0) begin
            active <= 1'b0;
            done   <= 1'b1;
            hit    <= 1'b0;
            idx    <= '0;
          end
        end else if (match) begin
          active <= 1'b0;
          done   <= 1'b1;
          hit    <= 1'b1;
          idx    <= c - 1'b1;
          cur    <= rdata;
        end else begin
          prev <= rdata;
          if (c == cnt) begin
            active <= 1'b0;
            done   <= 1'b1;
            hit    <= 1'b0;
            idx    <= cnt;
          end
        end
      end
    end
  end

endmodule

[src/segment_allocator_coalescing.sv]
// ----------------------------------------------------------------------------
// Segment allocator with coalescing
// Address-ordered hole and object tables with allocate and free requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears for a single cycle with done high and must be captured then, since
// the block cannot be held off. The scan unit and the shift sequencer each
// move one table entry per cycle through the single read port of each table
// RAM. After reset and after every configuration write the block rebuilds
// the tables in its init state, during which busy is high.
`include "assert_macros.svh"

module segment_allocator_coalescing #(
  parameter int HOLE_SLOTS   = 64,
  parameter int OBJECT_SLOTS = 64,
  parameter int ADDR_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic [sac_pkg::ADDR_W-1:0]       target_start,
  input  logic [sac_pkg::LEN_W-1:0]        request_length,
  output logic                             done,
  output logic [sac_pkg::STATUS_W-1:0]     status,
  output logic [sac_pkg::ADDR_W-1:0]       granted_start,
  output logic [sac_pkg::LEN_W-1:0]        granted_length,
  output logic [sac_pkg::CNT_OUT_W-1:0]    holes_in_use,
  output logic [sac_pkg::CNT_OUT_W-1:0]    objects_in_use,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import sac_pkg::*;

  localparam int HAW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
  localparam int OAW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
  localparam int HCW = $clog2(HOLE_SLOTS + 1);
  localparam int OCW = $clog2(OBJECT_SLOTS + 1);
  localparam int SCW = (HCW > OCW) ? HCW : OCW;
  localparam int SAW = (HAW > OAW) ? HAW : OAW;
  localparam int AW  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((33'd1 << AW) - 33'd1);

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] pool_base;
  logic [LEN_W-1:0]  pool_length;
  logic [HCW-1:0]    hole_count;
  logic [OCW-1:0]    object_count;
  logic [ADDR_W-1:0] key;
  logic [LEN_W-1:0]  size;
  logic [SCW-1:0]    hidx;
  logic [SCW-1:0]    oidx;
  seg_t              prev_seg;
  seg_t              cur_seg;
  seg_t              obj_seg;
  logic              has_next;
  logic [SCW-1:0]    mv_r;
  logic [SCW-1:0]    mv_w;
  logic              mv_pend;
  status_t           stat;
  logic [ADDR_W-1:0] gs;
  logic [LEN_W-1:0]  gl;

  logic              cfg_write;
  logic [ADDR_W-1:0] base_m;
  logic [ADDR_W-1:0] room;
  logic [ADDR_W:0]   len_m1;
  logic [ADDR_W:0]   room1;
  logic [LEN_W-1:0]  pool_clip;

  logic              h_we;
  logic [HAW-1:0]    h_waddr;
  seg_t              h_wdata;
  logic [HAW-1:0]    h_raddr;
  seg_t              h_rdata;
  logic              o_we;
  logic [OAW-1:0]    o_waddr;
  seg_t              o_wdata;
  logic [OAW-1:0]    o_raddr;
  seg_t              o_rdata;

  logic              scan_go;
  logic              scan_ge;
  logic [ADDR_W-1:0] scan_key;
  logic [SCW-1:0]    scan_cnt;
  seg_t              scan_rdata;
  logic [SAW-1:0]    scan_addr;
  logic              scan_done;
  logic              scan_hit;
  logic [SCW-1:0]    scan_idx;
  seg_t              scan_cur;
  seg_t              scan_prev;

  logic              mv_up;
  logic [SCW-1:0]    mv_n;
  logic [SCW-1:0]    mv_p;
  logic              mv_issue;
  logic              mv_fin;
  logic [SCW-1:0]    mv_rd;

  status_t           a_stat;
  logic [ADDR_W:0]   prev_end;
  logic [ADDR_W:0]   obj_end;
  logic              jp;
  logic              jn;
  logic              hole_full;
  logic [LEN_W-1:0]  both_len;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_DONE);
  assign status         = stat;
  assign granted_start  = gs;
  assign granted_length = gl;
  assign holes_in_use   = CNT_OUT_W'(hole_count);
  assign objects_in_use = CNT_OUT_W'(object_count);

  assign base_m    = pool_base & AMASK;
  assign room      = AMASK - base_m;
  assign len_m1    = {1'b0, pool_length} - 1'b1;
  assign room1     = {1'b0, room} + 1'b1;
  assign pool_clip = (len_m1 > {1'b0, room}) ? room1[LEN_W-1:0] : pool_length;

  assign scan_rdata = (state == ST_A_OSCAN || state == ST_F_OSCAN) ? o_rdata : h_rdata;

  assign mv_up    = (state == ST_A_OSHIFT) || (state == ST_F_HSHIFT);
  assign mv_n     = (state == ST_F_OREM) ? SCW'(object_count) : SCW'(hole_count);
  assign mv_p     = (state == ST_A_OSHIFT) ? oidx : hidx;
  assign mv_issue = mv_up ? (mv_r > mv_p) : (mv_r < mv_n);
  assign mv_fin   = !mv_issue && !mv_pend;
  assign mv_rd    = mv_up ? mv_r - 1'b1 : mv_r;

  always_comb begin
    if (!scan_hit) begin
      a_stat = STAT_NO_HOLE;
    end else if (size == '0) begin
      a_stat = STAT_ZERO;
    end else if (size > scan_cur.len) begin
      a_stat = STAT_TOO_LARGE;
    end else if (object_count >= OCW'(OBJECT_SLOTS)) begin
      a_stat = STAT_FULL;
    end else begin
      a_stat = STAT_OK;
    end
  end

  assign prev_end  = {1'b0, prev_seg.start} + {1'b0, prev_seg.len};
  assign obj_end   = {1'b0, key} + {1'b0, obj_seg.len};
  assign jp        = (hidx != '0) && (prev_end == {1'b0, key});
  assign jn        = has_next && (obj_end == {1'b0, cur_seg.start});
  assign hole_full = (hole_count >= HCW'(HOLE_SLOTS));
  assign both_len  = prev_seg.len + obj_seg.len + cur_seg.len;

  sac_ram #(.WIDTH($bits(seg_t)), .DEPTH(HOLE_SLOTS), .AW(HAW)) u_hole_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sac_ram #(.WIDTH($bits(seg_t)), .DEPTH(OBJECT_SLOTS), .AW(OAW)) u_obj_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  sac_scan #(.CW(SCW), .AW(SAW)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .go      (scan_go),
    .ge_mode (scan_ge),
    .key     (scan_key),
    .count   (scan_cnt),
    .rdata   (scan_rdata),
    .rd_addr (scan_addr),
    .done    (scan_done),
    .hit     (scan_hit),
    .idx     (scan_idx),
    .cur     (scan_cur),
    .prev    (scan_prev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else if (cfg_write) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    h_we       = 1'b0;
    h_waddr    = mv_w[HAW-1:0];
    h_wdata    = h_rdata;
    h_raddr    = mv_rd[HAW-1:0];
    o_we       = 1'b0;
    o_waddr    = mv_w[OAW-1:0];
    o_wdata    = o_rdata;
    o_raddr    = mv_rd[OAW-1:0];
    scan_go    = 1'b0;
    scan_ge    = 1'b0;
    scan_key   = key;
    scan_cnt   = SCW'(hole_count);
    case (state)
      ST_INIT: begin
        if (pool_length != '0) begin
          h_we    = 1'b1;
          h_waddr = '0;
          h_wdata = '{start: base_m, len: pool_clip};
        end
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          scan_go  = 1'b1;
          scan_key = target_start & AMASK;
          if (mode == MODE_FREE) begin
            scan_cnt   = SCW'(object_count);
            state_next = ST_F_OSCAN;
          end else begin
            state_next = ST_A_HSCAN;
          end
        end
      end
      ST_A_HSCAN: begin
        h_raddr = scan_addr[HAW-1:0];
        if (scan_done) begin
          state_next = (a_stat == STAT_OK) ? ST_A_HUPD : ST_DONE;
        end
      end
      ST_A_HUPD: begin
        if (cur_seg.len == size) begin
          state_next = ST_A_HREM;
        end else begin
          h_we       = 1'b1;
          h_waddr    = hidx[HAW-1:0];
          h_wdata    = '{start: (key + size) & AMASK, len: cur_seg.len - size};
          scan_go    = 1'b1;
          scan_ge    = 1'b1;
          scan_cnt   = SCW'(object_count);
          state_next = ST_A_OSCAN;
        end
      end
      ST_A_HREM: begin
        h_we = mv_pend;
        if (mv_fin) begin
          scan_go    = 1'b1;
          scan_ge    = 1'b1;
          scan_cnt   = SCW'(object_count);
          state_next = ST_A_OSCAN;
        end
      end
      ST_A_OSCAN: begin
        o_raddr = scan_addr[OAW-1:0];
        if (scan_done) begin
          state_next = ST_A_OSHIFT;
        end
      end
      ST_A_OSHIFT: begin
        o_we = mv_pend;
        if (mv_fin) begin
          o_we       = 1'b1;
          o_waddr    = oidx[OAW-1:0];
          o_wdata    = '{start: key, len: size};
          state_next = ST_DONE;
        end
      end
      ST_F_OSCAN: begin
        o_raddr = scan_addr[OAW-1:0];
        if (scan_done) begin
          if (!scan_hit) begin
            state_next = ST_DONE;
          end else begin
            scan_go    = 1'b1;
            scan_ge    = 1'b1;
            state_next = ST_F_HSCAN;
          end
        end
      end
      ST_F_HSCAN: begin
        h_raddr = scan_addr[HAW-1:0];
        if (scan_done) begin
          state_next = ST_F_JOIN;
        end
      end
      ST_F_JOIN: begin
        if (jp && jn) begin
          h_we       = 1'b1;
          h_waddr    = HAW'(hidx - 1'b1);
          h_wdata    = '{start: prev_seg.start, len: both_len};
          state_next = ST_F_HREM;
        end else if (jp) begin
          h_we       = 1'b1;
          h_waddr    = HAW'(hidx - 1'b1);
          h_wdata    = '{start: prev_seg.start, len: prev_seg.len + obj_seg.len};
          state_next = ST_F_OREM;
        end else if (jn) begin
          h_we       = 1'b1;
          h_waddr    = hidx[HAW-1:0];
          h_wdata    = '{start: key, len: cur_seg.len + obj_seg.len};
          state_next = ST_F_OREM;
        end else if (hole_full) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_F_HSHIFT;
        end
      end
      ST_F_HREM: begin
        h_we = mv_pend;
        if (mv_fin) begin
          state_next = ST_F_OREM;
        end
      end
      ST_F_HSHIFT: begin
        h_we = mv_pend;
        if (mv_fin) begin
          h_we       = 1'b1;
          h_waddr    = hidx[HAW-1:0];
          h_wdata    = '{start: key, len: obj_seg.len};
          state_next = ST_F_OREM;
        end
      end
      ST_F_OREM: begin
        o_we = mv_pend;
        if (mv_fin) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= '0;
      pool_length  <= 32'd65536;
      hole_count   <= '0;
      object_count <= '0;
      mv_pend      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_POOL_BASE:   pool_base   <= cfg_data;
          CFG_POOL_LENGTH: pool_length <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_A_HREM || state == ST_A_OSHIFT || state == ST_F_HREM ||
          state == ST_F_HSHIFT || state == ST_F_OREM) begin
        mv_pend <= mv_issue;
        if (mv_issue) begin
          mv_w <= mv_up ? mv_r : mv_r - 1'b1;
          mv_r <= mv_up ? mv_r - 1'b1 : mv_r + 1'b1;
        end
      end
      case (state)
        ST_INIT: begin
          hole_count   <= (pool_length == '0) ? '0 : HCW'(1);
          object_count <= '0;
        end
        ST_IDLE: begin
          if (start) begin
            key  <= target_start & AMASK;
            size <= request_length;
          end
        end
        ST_A_HSCAN: begin
          if (scan_done) begin
            hidx    <= scan_idx;
            cur_seg <= scan_cur;
            stat    <= a_stat;
            gs      <= '0;
            gl      <= '0;
          end
        end
        ST_A_HUPD: begin
          mv_r    <= hidx + 1'b1;
          mv_pend <= 1'b0;
        end
        ST_A_HREM: begin
          if (mv_fin) begin
            hole_count <= hole_count - 1'b1;
          end
        end
        ST_A_OSCAN: begin
          if (scan_done) begin
            oidx    <= scan_idx;
            mv_r    <= SCW'(object_count);
            mv_pend <= 1'b0;
          end
        end
        ST_A_OSHIFT: begin
          if (mv_fin) begin
            object_count <= object_count + 1'b1;
            gs           <= key;
            gl           <= size;
          end
        end
        ST_F_OSCAN: begin
          if (scan_done) begin
            oidx    <= scan_idx;
            obj_seg <= scan_cur;
            stat    <= scan_hit ? STAT_OK : STAT_NO_OBJECT;
            gs      <= '0;
            gl      <= '0;
          end
        end
        ST_F_HSCAN: begin
          if (scan_done) begin
            hidx     <= scan_idx;
            prev_seg <= scan_prev;
            cur_seg  <= scan_cur;
            has_next <= scan_hit;
          end
        end
        ST_F_JOIN: begin
          mv_pend <= 1'b0;
          if (jp && jn) begin
            gs   <= prev_seg.start;
            gl   <= both_len;
            mv_r <= hidx + 1'b1;
          end else if (jp) begin
            gs   <= prev_seg.start;
            gl   <= prev_seg.len + obj_seg.len;
            mv_r <= oidx + 1'b1;
          end else if (jn) begin
            gs   <= key;
            gl   <= cur_seg.len + obj_seg.len;
            mv_r <= oidx + 1'b1;
          end else if (hole_full) begin
            stat <= STAT_FULL;
          end else begin
            gs   <= key;
            gl   <= obj_seg.len;
            mv_r <= SCW'(hole_count);
          end
        end
        ST_F_HREM: begin
          if (mv_fin) begin
            hole_count <= hole_count - 1'b1;
            mv_r       <= oidx + 1'b1;
          end
        end
        ST_F_HSHIFT: begin
          if (mv_fin) begin
            hole_count <= hole_count + 1'b1;
            mv_r       <= oidx + 1'b1;
          end
        end
        ST_F_OREM: begin
          if (mv_fin) begin
            object_count <= object_count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_hole_bound, clk, rst, hole_count <= HCW'(HOLE_SLOTS), "hole count overflow")
  `ASSERT_ALWAYS(a_obj_bound, clk, rst, object_count <= OCW'(OBJECT_SLOTS), "object count overflow")
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `ASSERT_IMPLIES(a_err_zero, clk, rst, done && stat != STAT_OK, gs == '0 && gl == '0, "error result carries a segment")

endmodule
